[design/heater_link_frame_receiver_core_defines.svh]
// Assertion macros used by the frame receiver sequencer (hlfr_rx)
`ifndef HEATER_LINK_FRAME_RECEIVER_CORE_DEFINES_SVH
`define HEATER_LINK_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HLFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define HLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hlfr_pkg.sv]
// Shared types and constants of the heater link frame receiver
`timescale 1ns / 1ps
`default_nettype none

package hlfr_pkg;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_PV   = 2'd1;
  localparam logic [1:0] KIND_TIME = 2'd2;

  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;

  localparam int HDR_BYTES   = 3;
  localparam int LEN_EXTRA   = 5;
  localparam int REPLY_BYTES = 6;
  localparam int ACK_BYTES   = 6;
  localparam int REQ_BYTES   = 8;
  localparam int TIME_FIELDS = 6;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_REPLY,
    PH_MSG
  } rx_phase_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ACK,
    SEQ_REQ,
    SEQ_PV,
    SEQ_TIME
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [4:0] index;
    logic [7:0] tx_byte;
    logic       last;
    logic       hi_zero;
    logic       lo_zero;
    logic       halve;
  } issue_t;

endpackage

`default_nettype wire

[design/hlfr_in_if.sv]
// Input channel: received bytes and restart requests
`timescale 1ns / 1ps
`default_nettype none

interface hlfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/hlfr_out_if.sv]
// Output channel: transmit bytes, process values and time fields
`timescale 1ns / 1ps
`default_nettype none

interface hlfr_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [4:0]        index;
  logic signed [15:0] value;
  logic              last;

  modport source (output valid, output kind, output index, output value, output last,
                  input ready);
  modport sink (input valid, input kind, input index, input value, input last,
                output ready);
endinterface

`default_nettype wire

[design/hlfr_store.sv]
// Frame store: one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module hlfr_store #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_hi,
  input  wire logic [AW-1:0] raddr_lo,
  output logic      [7:0]    rdata_hi,
  output logic      [7:0]    rdata_lo
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_hi <= mem[raddr_hi];
      rdata_lo <= mem[raddr_lo];
    end
  end

endmodule

`default_nettype wire

[design/hlfr_rx.sv]
// Frame assembly and result sequencer of the frame receiver
`timescale 1ns / 1ps
`default_nettype none
`include "heater_link_frame_receiver_core_defines.svh"

module hlfr_rx #(
  parameter int BUFFER_BYTES = 128,
  parameter int PROCESS_VALUES = 24,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  hlfr_in_if.sink               link,
  input  wire logic [15:0]      user_id,
  input  wire logic             adv,
  output logic                  we,
  output logic      [AW-1:0]    waddr,
  output logic      [7:0]       wdata,
  output logic      [AW-1:0]    raddr_hi,
  output logic      [AW-1:0]    raddr_lo,
  output hlfr_pkg::issue_t      issue
);

  localparam logic [31:0] HALVED_SET = 32'h00FE_C008;
  localparam logic [7:0]  PV_BASE    = 8'd3;

  hlfr_pkg::seq_state_t state, state_next;
  hlfr_pkg::rx_phase_t  phase, phase_next;
  logic [4:0]    cnt, cnt_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] total, total_next;
  logic          rb_sent, rb_sent_next;
  logic [7:0]    b0, b1, q0, q1;
  logic [15:0]   csum;
  logic [15:0]   sum_now;
  logic          ok;
  logic [7:0]    req_second;
  logic          req_final;
  logic          acc, op, wr, big, finish;
  logic          ack_end, start_ra, start_rb;
  logic [9:0]    tot_wide;
  logic [7:0]    pos_hi, pos_lo;

  function automatic logic [7:0] req_byte(input logic [7:0] second, input logic [15:0] uid,
                                          input logic [2:0] n);
    logic [15:0] cs;
    cs = 16'(hlfr_pkg::CH_R) + 16'(second) + 16'd3 + 16'(uid[15:8]) + 16'(uid[7:0]);
    case (n)
      3'd0: req_byte = hlfr_pkg::CH_R;
      3'd1: req_byte = second;
      3'd2: req_byte = 8'd3;
      3'd3: req_byte = 8'd0;
      3'd4: req_byte = uid[15:8];
      3'd5: req_byte = uid[7:0];
      3'd6: req_byte = cs[15:8];
      default: req_byte = cs[7:0];
    endcase
  endfunction

  function automatic logic [7:0] ack_byte(input logic [7:0] f0, input logic [7:0] f1,
                                          input logic a, input logic [2:0] n);
    logic [15:0] cs;
    cs = 16'(f0) + 16'(f1) + 16'd1 + 16'(a);
    case (n)
      3'd0: ack_byte = f0;
      3'd1: ack_byte = f1;
      3'd2: ack_byte = 8'd1;
      3'd3: ack_byte = {7'd0, a};
      3'd4: ack_byte = cs[15:8];
      default: ack_byte = cs[7:0];
    endcase
  endfunction

  function automatic logic [7:0] time_pos(input logic [2:0] n);
    case (n)
      3'd0: time_pos = 8'd6;
      3'd1: time_pos = 8'd7;
      3'd2: time_pos = 8'd9;
      3'd3: time_pos = 8'd5;
      3'd4: time_pos = 8'd4;
      default: time_pos = 8'd3;
    endcase
  endfunction

  assign acc      = link.valid && link.ready;
  assign op       = link.operation;
  assign wr       = acc && !op && (32'(fill) < BUFFER_BYTES);
  assign tot_wide = 10'(link.rx_byte) + 10'(hlfr_pkg::LEN_EXTRA);
  assign big      = 32'(tot_wide) > BUFFER_BYTES;
  assign sum_now  = csum + 16'(q1);

  assign we    = wr;
  assign waddr = fill[AW-1:0];
  assign wdata = link.rx_byte;

  always_comb begin
    phase_next = phase;
    fill_next  = fill;
    total_next = total;
    finish     = 1'b0;
    if (acc && op) begin
      phase_next = hlfr_pkg::PH_HUNT;
      fill_next  = '0;
      total_next = '0;
    end else if (acc) begin
      if (wr) begin
        fill_next = fill + 1'b1;
      end else begin
        fill_next  = '0;
        phase_next = hlfr_pkg::PH_HUNT;
      end
      case (phase_next)
        hlfr_pkg::PH_HUNT: begin
          if (fill_next >= FW'(hlfr_pkg::HDR_BYTES)) begin
            if (big) begin
              fill_next  = '0;
              total_next = '0;
            end else begin
              total_next = FW'(tot_wide);
              if (b0 == hlfr_pkg::CH_R) begin
                phase_next = hlfr_pkg::PH_REPLY;
              end else if (b0 == hlfr_pkg::CH_M) begin
                phase_next = hlfr_pkg::PH_MSG;
              end else begin
                fill_next = '0;
              end
            end
          end
        end
        hlfr_pkg::PH_REPLY: begin
          if (fill_next >= FW'(hlfr_pkg::REPLY_BYTES)) begin
            fill_next  = '0;
            phase_next = hlfr_pkg::PH_HUNT;
          end
        end
        hlfr_pkg::PH_MSG: begin
          if (fill_next >= total) begin
            finish     = 1'b1;
            fill_next  = '0;
            phase_next = hlfr_pkg::PH_HUNT;
          end
        end
        default: begin
          fill_next  = '0;
          phase_next = hlfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  assign ack_end  = (state == hlfr_pkg::SEQ_ACK) && adv &&
                    (cnt == 5'(hlfr_pkg::ACK_BYTES - 1));
  assign start_ra = (state == hlfr_pkg::SEQ_IDLE) && acc && op;
  assign start_rb = ack_end && (b1 == hlfr_pkg::CH_2) && !rb_sent;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rb_sent_next = rb_sent;
    case (state)
      hlfr_pkg::SEQ_IDLE: begin
        if (acc && op) begin
          state_next   = hlfr_pkg::SEQ_REQ;
          cnt_next     = '0;
          rb_sent_next = 1'b0;
        end else if (finish) begin
          state_next = hlfr_pkg::SEQ_ACK;
          cnt_next   = '0;
        end
      end
      hlfr_pkg::SEQ_ACK: begin
        if (adv) begin
          if (cnt == 5'(hlfr_pkg::ACK_BYTES - 1)) begin
            cnt_next = '0;
            if (b1 == hlfr_pkg::CH_1) begin
              state_next = hlfr_pkg::SEQ_PV;
            end else if (b1 == hlfr_pkg::CH_2) begin
              if (!rb_sent) begin
                state_next   = hlfr_pkg::SEQ_REQ;
                rb_sent_next = 1'b1;
              end else begin
                state_next = hlfr_pkg::SEQ_TIME;
              end
            end else begin
              state_next = hlfr_pkg::SEQ_IDLE;
            end
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      hlfr_pkg::SEQ_REQ: begin
        if (adv) begin
          if (cnt == 5'(hlfr_pkg::REQ_BYTES - 1)) begin
            cnt_next   = '0;
            state_next = req_final ? hlfr_pkg::SEQ_IDLE : hlfr_pkg::SEQ_TIME;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      hlfr_pkg::SEQ_PV: begin
        if (adv) begin
          if (cnt == 5'(PROCESS_VALUES - 1)) begin
            cnt_next   = '0;
            state_next = hlfr_pkg::SEQ_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      hlfr_pkg::SEQ_TIME: begin
        if (adv) begin
          if (cnt == 5'(hlfr_pkg::TIME_FIELDS - 1)) begin
            cnt_next   = '0;
            state_next = hlfr_pkg::SEQ_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = hlfr_pkg::SEQ_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    link.ready = (state == hlfr_pkg::SEQ_IDLE);
    issue      = '0;
    pos_hi     = '0;
    pos_lo     = '0;
    case (state)
      hlfr_pkg::SEQ_ACK: begin
        issue.valid   = 1'b1;
        issue.kind    = hlfr_pkg::KIND_TX;
        issue.tx_byte = ack_byte(b0, b1, ok, cnt[2:0]);
        issue.last    = (cnt == 5'(hlfr_pkg::ACK_BYTES - 1)) &&
                        (b1 != hlfr_pkg::CH_1) && (b1 != hlfr_pkg::CH_2);
      end
      hlfr_pkg::SEQ_REQ: begin
        issue.valid   = 1'b1;
        issue.kind    = hlfr_pkg::KIND_TX;
        issue.tx_byte = req_byte(req_second, user_id, cnt[2:0]);
        issue.last    = (cnt == 5'(hlfr_pkg::REQ_BYTES - 1)) && req_final;
      end
      hlfr_pkg::SEQ_PV: begin
        pos_hi        = PV_BASE + {2'd0, cnt, 1'b0};
        pos_lo        = pos_hi + 8'd1;
        issue.valid   = 1'b1;
        issue.kind    = hlfr_pkg::KIND_PV;
        issue.index   = cnt;
        issue.hi_zero = 32'(pos_hi) >= BUFFER_BYTES;
        issue.lo_zero = 32'(pos_lo) >= BUFFER_BYTES;
        issue.halve   = HALVED_SET[cnt];
        issue.last    = (cnt == 5'(PROCESS_VALUES - 1));
      end
      hlfr_pkg::SEQ_TIME: begin
        pos_lo        = time_pos(cnt[2:0]);
        issue.valid   = 1'b1;
        issue.kind    = hlfr_pkg::KIND_TIME;
        issue.index   = cnt;
        issue.hi_zero = 1'b1;
        issue.lo_zero = 32'(pos_lo) >= BUFFER_BYTES;
        issue.last    = (cnt == 5'(hlfr_pkg::TIME_FIELDS - 1));
      end
      default: begin
        issue = '0;
      end
    endcase
  end

  assign raddr_hi = AW'(pos_hi);
  assign raddr_lo = AW'(pos_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hlfr_pkg::SEQ_IDLE;
      cnt     <= '0;
      phase   <= hlfr_pkg::PH_HUNT;
      fill    <= '0;
      total   <= '0;
      rb_sent <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      phase   <= phase_next;
      fill    <= fill_next;
      total   <= total_next;
      rb_sent <= rb_sent_next;
    end
  end

  // running checksum excludes the two newest bytes
  always_ff @(posedge clk) begin
    if (wr) begin
      if (fill == '0) begin
        b0   <= link.rx_byte;
        csum <= '0;
        q1   <= '0;
        q0   <= link.rx_byte;
      end else begin
        if (fill == FW'(1)) begin
          b1 <= link.rx_byte;
        end
        csum <= sum_now;
        q1   <= q0;
        q0   <= link.rx_byte;
      end
    end
    if (finish) begin
      ok <= ({q0, link.rx_byte} == sum_now);
    end
    if (start_ra) begin
      req_second <= hlfr_pkg::CH_A;
      req_final  <= 1'b1;
    end else if (start_rb) begin
      req_second <= hlfr_pkg::CH_B;
      req_final  <= 1'b0;
    end
  end

  `HLFR_ASSERT_IMPL(a_msg_fill, (phase == hlfr_pkg::PH_MSG), (fill < total), "message fill reached its total")
  `HLFR_ASSERT_IMPL(a_time_rb, (state == hlfr_pkg::SEQ_TIME), rb_sent, "time fields without Rb request")
  `HLFR_ASSERT_NEXT(a_finish_ack, finish, ((state == hlfr_pkg::SEQ_ACK) && (cnt == 5'd0)), "finished frame did not start ACK")

endmodule

`default_nettype wire

[design/hlfr_out.sv]
// Result formatting stage and output register of the frame receiver
`timescale 1ns / 1ps
`default_nettype none

module hlfr_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hlfr_pkg::issue_t issue,
  input  wire logic [7:0]       rd_hi,
  input  wire logic [7:0]       rd_lo,
  output logic                  adv,
  hlfr_out_if.source            result
);

  hlfr_pkg::issue_t   d;
  logic               out_valid;
  logic [1:0]         kind;
  logic [4:0]         index;
  logic signed [15:0] value;
  logic               last;
  logic [7:0]         hi, lo;
  logic signed [15:0] raw;
  logic [16:0]        half_sum;
  logic signed [15:0] pv_val;
  logic [15:0]        time_val;
  logic signed [15:0] value_next;

  assign hi       = d.hi_zero ? 8'd0 : rd_hi;
  assign lo       = d.lo_zero ? 8'd0 : rd_lo;
  assign raw      = signed'({hi, lo});
  assign half_sum = {raw[15], raw} + 17'(raw[15]);
  assign pv_val   = d.halve ? signed'(half_sum[16:1]) : raw;
  assign time_val = 16'({lo[7:4], 3'd0}) + 16'({lo[7:4], 1'b0}) + 16'(lo[3:0]);

  always_comb begin
    case (d.kind)
      hlfr_pkg::KIND_PV:   value_next = pv_val;
      hlfr_pkg::KIND_TIME: value_next = signed'(time_val);
      default:             value_next = signed'(16'(d.tx_byte));
    endcase
  end

  assign adv = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d         <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d         <= issue;
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind  <= d.kind;
      index <= d.index;
      value <= value_next;
      last  <= d.last;
    end
  end

  assign result.valid = out_valid;
  assign result.kind  = kind;
  assign result.index = index;
  assign result.value = value;
  assign result.last  = last;

endmodule

`default_nettype wire

[design/heater_link_frame_receiver_core.sv]
// Heater link frame receiver: top level
// Use: bytes from the serial link enter on link (operation 0, rx_byte); operation 1
// restarts the receiver and queues an Ra request. Results leave on result as a
// stream of kind/index/value items, the final one of each input flagged by last.
// Write user_id via cfg_write/cfg_data only while the block is idle (unenforced).
// Flow: a byte that completes nothing leaves link.ready high. A byte that
// completes an M frame holds link.ready low while its results are issued, one
// per cycle unless result.ready stalls them: 6 (ACK/NAK), 6 + PROCESS_VALUES (M1),
// 6 + 8 + 6 (first M2) or 6 + 6 (later M2); a restart issues 8. The rate is
// set by the two-port frame store, read once per issued result, with one read
// latency stage and one output register that every result passes through.
// Reset: clears frame assembly state, the Rb flag and user_id; the store is
// not cleared, so no clearing pass runs and link.ready rises right after reset.
// Stall: when result.ready is low with a result valid, the output register, the
// read stage and the sequencer all hold; no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module heater_link_frame_receiver_core #(
  parameter int BUFFER_BYTES = 128,
  parameter int PROCESS_VALUES = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  hlfr_in_if.sink          link,
  hlfr_out_if.source       result
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [15:0]      user_id;
  logic             adv;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [AW-1:0]    raddr_hi, raddr_lo;
  logic [7:0]       rdata_hi, rdata_lo;
  hlfr_pkg::issue_t issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_id <= '0;
    end else if (cfg_write) begin
      user_id <= cfg_data;
    end
  end

  hlfr_rx #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .PROCESS_VALUES (PROCESS_VALUES)
  ) u_rx (
    .clk      (clk),
    .rst      (rst),
    .link     (link),
    .user_id  (user_id),
    .adv      (adv),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr_hi (raddr_hi),
    .raddr_lo (raddr_lo),
    .issue    (issue)
  );

  hlfr_store #(
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk      (clk),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (adv),
    .raddr_hi (raddr_hi),
    .raddr_lo (raddr_lo),
    .rdata_hi (rdata_hi),
    .rdata_lo (rdata_lo)
  );

  hlfr_out u_out (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .rd_hi  (rdata_hi),
    .rd_lo  (rdata_lo),
    .adv    (adv),
    .result (result)
  );

endmodule

`default_nettype wire
